// ----- rtl/core/tld_pkg.sv -----
package tld_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_DRAIN = 2'd1;
    localparam logic [1:0] FUNC_ARM   = 2'd2;

    // Scroll commands
    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    // Configuration register indexes
    localparam logic [7:0] CFG_UP_KEY   = 8'd0;
    localparam logic [7:0] CFG_DOWN_KEY = 8'd1;

    // Character codes
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;

    // Field widths
    localparam int CNT_W  = 12;
    localparam int CHAR_W = 8;

    // What the second stage has to do for a beat
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_POP,
        KIND_ARM
    } tld_kind_t;

    // First stage to second stage control
    typedef struct packed {
        tld_kind_t         kind;
        logic [CNT_W-1:0]  size;
        logic [1:0]        scroll;
        logic              dropped;
    } tld_stage_t;

endpackage

// ----- rtl/core/tld_ram.sv -----
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tty_line_discipline_fifo.sv -----
// Terminal line discipline: key FIFO, read assembly, echo and scroll commands.
// A beat accepted is registered in the stage register, then in the result registers when they are free.
// Throughput: one beat per cycle while the result channel does not stall; the FIFO RAM read and the
// counter update each take one stage, so drains may follow one another with no gap.
// Reset (rst_n low, asynchronous) empties the FIFO, clears the counters, cancels
// any pending read and clears both key code registers; FIFO contents stay as-is.
module tty_line_discipline_fifo
    import tld_pkg::*;
#(
    parameter int FIFO_DEPTH  = 256,
    parameter int MAX_REQUEST = 4095
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  key_code,
    input  logic        is_make,
    input  logic        is_extended,
    input  logic [11:0] request_size,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        store_valid,
    output logic [11:0] store_index,
    output logic [7:0]  store_char,
    output logic        echo_valid,
    output logic [7:0]  echo_char,
    output logic        request_done,
    output logic [11:0] done_count,
    output logic [1:0]  scroll_cmd,
    output logic        dropped,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam int SAT = (MAX_REQUEST < 4095) ? MAX_REQUEST : 4095;
    localparam logic [CNT_W-1:0] SAT_SIZE = CNT_W'(SAT);

    // Configuration registers
    logic [7:0] up_key_reg;
    logic [7:0] down_key_reg;

    // FIFO pointers
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;

    // Read assembly counters
    logic [CNT_W-1:0] xfer_reg, xfer_next;
    logic [CNT_W-1:0] remain_reg, remain_next;

    // Stage and output handshake
    logic       s1_valid_reg;
    tld_stage_t s1_reg, s1_next;
    logic       out_valid_reg;
    logic       out_free, s1_move, accept;
    logic       fifo_full, fifo_empty, push_ok, pop_ok;
    logic [7:0] pop_char;

    // Result registers
    logic              st_v_reg, st_v_next;
    logic [CNT_W-1:0]  st_i_reg, st_i_next;
    logic [7:0]        st_c_reg, st_c_next;
    logic              ec_v_reg, ec_v_next;
    logic [7:0]        ec_c_reg, ec_c_next;
    logic              dn_v_reg, dn_v_next;
    logic [CNT_W-1:0]  dn_c_reg, dn_c_next;
    logic [1:0]        scroll_reg;
    logic              drop_reg;

    // Handshake: the stage moves on when the result register is free
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_key_reg   <= '0;
            down_key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_UP_KEY)
            begin
                up_key_reg <= cfg_data;
            end
            else if (cfg_index == CFG_DOWN_KEY)
            begin
                down_key_reg <= cfg_data;
            end
        end
    end

    // Stage 0: FIFO pointer logic, scroll and drop decisions
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign fifo_full  = (wr_ptr_inc == rd_ptr_reg);
    assign fifo_empty = (wr_ptr_reg == rd_ptr_reg);
    assign push_ok = accept && (func == FUNC_PUSH) && is_make && !is_extended && !fifo_full;
    assign pop_ok  = accept && (func == FUNC_DRAIN) && !fifo_empty;

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = pop_ok  ? rd_ptr_inc : rd_ptr_reg;

        s1_next.kind    = KIND_NONE;
        s1_next.size    = (request_size > SAT_SIZE) ? SAT_SIZE : request_size;
        s1_next.scroll  = SCROLL_NONE;
        s1_next.dropped = 1'b0;
        if (pop_ok)
        begin
            s1_next.kind = KIND_POP;
        end
        else if (func == FUNC_ARM)
        begin
            s1_next.kind = KIND_ARM;
        end
        if ((func == FUNC_PUSH) && is_make)
        begin
            if (is_extended)
            begin
                if (key_code == up_key_reg)
                begin
                    s1_next.scroll = SCROLL_UP;
                end
                else if (key_code == down_key_reg)
                begin
                    s1_next.scroll = SCROLL_DOWN;
                end
            end
            else if (fifo_full)
            begin
                s1_next.dropped = 1'b1;
            end
        end
    end

    tld_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (wr_ptr_reg),
        .wdata (key_code),
        .re    (pop_ok),
        .raddr (rd_ptr_reg),
        .rdata (pop_char)
    );

    // Stage 1: read assembly on the popped character
    always_comb
    begin
        xfer_next   = xfer_reg;
        remain_next = remain_reg;
        st_v_next   = 1'b0;
        st_i_next   = '0;
        st_c_next   = '0;
        ec_v_next   = 1'b0;
        ec_c_next   = '0;
        dn_v_next   = 1'b0;
        dn_c_next   = '0;
        case (s1_reg.kind)
            KIND_POP:
            begin
                if (remain_reg != '0)
                begin
                    if ((pop_char >= CH_SPACE) && (pop_char <= CH_TILDE))
                    begin
                        st_v_next   = 1'b1;
                        st_i_next   = xfer_reg;
                        st_c_next   = pop_char;
                        ec_v_next   = 1'b1;
                        ec_c_next   = pop_char;
                        remain_next = remain_reg - 1'b1;
                        xfer_next   = xfer_reg + 1'b1;
                        if (remain_reg == CNT_W'(1))
                        begin
                            dn_v_next = 1'b1;
                            dn_c_next = xfer_reg + 1'b1;
                        end
                    end
                    else if (pop_char == CH_NEWLINE)
                    begin
                        ec_v_next   = 1'b1;
                        ec_c_next   = pop_char;
                        dn_v_next   = 1'b1;
                        dn_c_next   = xfer_reg;
                        remain_next = '0;
                    end
                    else if ((pop_char == CH_BACKSPACE) && (xfer_reg != '0))
                    begin
                        ec_v_next   = 1'b1;
                        ec_c_next   = pop_char;
                        xfer_next   = xfer_reg - 1'b1;
                        remain_next = remain_reg + 1'b1;
                    end
                end
            end
            KIND_ARM:
            begin
                remain_next = s1_reg.size;
                xfer_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            xfer_reg      <= '0;
            remain_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            if (s1_move)
            begin
                xfer_reg   <= xfer_next;
                remain_reg <= remain_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            st_v_reg   <= st_v_next;
            st_i_reg   <= st_i_next;
            st_c_reg   <= st_c_next;
            ec_v_reg   <= ec_v_next;
            ec_c_reg   <= ec_c_next;
            dn_v_reg   <= dn_v_next;
            dn_c_reg   <= dn_c_next;
            scroll_reg <= s1_reg.scroll;
            drop_reg   <= s1_reg.dropped;
        end
    end

    assign out_valid    = out_valid_reg;
    assign store_valid  = st_v_reg;
    assign store_index  = st_i_reg;
    assign store_char   = st_c_reg;
    assign echo_valid   = ec_v_reg;
    assign echo_char    = ec_c_reg;
    assign request_done = dn_v_reg;
    assign done_count   = dn_c_reg;
    assign scroll_cmd   = scroll_reg;
    assign dropped      = drop_reg;

endmodule

// ----- rtl/core/tld_checker.sv -----
module tld_checker
    import tld_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        store_valid,
    input logic [11:0] store_index,
    input logic [7:0]  store_char,
    input logic        echo_valid,
    input logic [7:0]  echo_char,
    input logic        request_done,
    input logic [11:0] done_count,
    input logic [1:0]  scroll_cmd,
    input logic        dropped
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(store_index) && $stable(echo_char))
        else $error("result beat changed while stalled");

    // Every stored character is also echoed
    a_store_echo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_valid |-> echo_valid && (echo_char == store_char))
        else $error("stored character not echoed");

    // A scroll command carries nothing else
    a_scroll_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (scroll_cmd != SCROLL_NONE)
        |-> !store_valid && !echo_valid && !request_done && !dropped)
        else $error("scroll beat carries other results");

    // Completion on the last stored character counts that character
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_valid && request_done |-> done_count == store_index + 12'd1)
        else $error("completion count mismatch");

    // Unused scroll code never appears
    a_scroll_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (scroll_cmd == SCROLL_NONE) || (scroll_cmd == SCROLL_UP)
                      || (scroll_cmd == SCROLL_DOWN))
        else $error("invalid scroll code");

endmodule

bind tty_line_discipline_fifo tld_checker u_tld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .store_valid  (store_valid),
    .store_index  (store_index),
    .store_char   (store_char),
    .echo_valid   (echo_valid),
    .echo_char    (echo_char),
    .request_done (request_done),
    .done_count   (done_count),
    .scroll_cmd   (scroll_cmd),
    .dropped      (dropped)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tld_pkg::*;

    // Code that the block leaves unused
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 50;
    localparam int RANDOM_PER_PH = 60;

    // One beat on the input channel
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  key;
        logic        make;
        logic        ext;
        logic [11:0] size;
    } tty_beat_t;

    // One beat on the result channel
    typedef struct packed {
        logic        store_valid;
        logic [11:0] store_index;
        logic [7:0]  store_char;
        logic        echo_valid;
        logic [7:0]  echo_char;
        logic        request_done;
        logic [11:0] done_count;
        logic [1:0]  scroll_cmd;
        logic        dropped;
    } tty_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FUNC_PUSH;
    logic [7:0]  key_code = 8'h00;
    logic        is_make = 1'b0;
    logic        is_extended = 1'b0;
    logic [11:0] request_size = 12'h000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        store_valid;
    logic [11:0] store_index;
    logic [7:0]  store_char;
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic        request_done;
    logic [11:0] done_count;
    logic [1:0]  scroll_cmd;
    logic        dropped;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = CFG_UP_KEY;
    logic [7:0]  cfg_data = 8'h00;

    tty_line_discipline_fifo u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .key_code     (key_code),
        .is_make      (is_make),
        .is_extended  (is_extended),
        .request_size (request_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .store_valid  (store_valid),
        .store_index  (store_index),
        .store_char   (store_char),
        .echo_valid   (echo_valid),
        .echo_char    (echo_char),
        .request_done (request_done),
        .done_count   (done_count),
        .scroll_cmd   (scroll_cmd),
        .dropped      (dropped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow of the block state
    logic [7:0]  key_ring [256];
    logic [7:0]  ring_rd = 8'd0;
    logic [7:0]  ring_wr = 8'd0;
    logic [11:0] chars_taken = 12'd0;
    logic [11:0] chars_left = 12'd0;
    logic [7:0]  up_code = 8'h00;
    logic [7:0]  down_code = 8'h00;

    tty_beat_t    beats_to_send [$];
    tty_outcome_t outcomes_due [$];
    tty_beat_t    nxt_beat;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        stall_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    int unsigned beats_queued = 0;
    int unsigned beats_sent = 0;
    int unsigned useful_beats = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned n_stores = 0;
    int unsigned n_echoes = 0;
    int unsigned n_done = 0;
    int unsigned n_scrolls = 0;
    int unsigned n_drops = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // What the block should answer to one beat; updates the shadow state
    function automatic tty_outcome_t discipline_outcome(input tty_beat_t b);
        tty_outcome_t r;
        logic [7:0]   ch;
        r = '0;
        case (b.func)
            FUNC_PUSH:
            begin
                if (b.make)
                begin
                    if (b.ext)
                    begin
                        if (b.key == up_code)
                            r.scroll_cmd = SCROLL_UP;
                        else if (b.key == down_code)
                            r.scroll_cmd = SCROLL_DOWN;
                    end
                    else if (8'(ring_wr + 8'd1) == ring_rd)
                        r.dropped = 1'b1;
                    else
                    begin
                        key_ring[ring_wr] = b.key;
                        ring_wr = 8'(ring_wr + 8'd1);
                    end
                end
            end
            FUNC_DRAIN:
            begin
                if (ring_rd != ring_wr)
                begin
                    ch = key_ring[ring_rd];
                    ring_rd = 8'(ring_rd + 8'd1);
                    // characters popped with no read pending are thrown away
                    if (chars_left != 12'd0)
                    begin
                        if (ch >= CH_SPACE && ch <= CH_TILDE)
                        begin
                            r.store_valid = 1'b1;
                            r.store_index = chars_taken;
                            r.store_char  = ch;
                            r.echo_valid  = 1'b1;
                            r.echo_char   = ch;
                            chars_left  = chars_left - 12'd1;
                            chars_taken = chars_taken + 12'd1;
                            if (chars_left == 12'd0)
                            begin
                                r.request_done = 1'b1;
                                r.done_count   = chars_taken;
                            end
                        end
                        else if (ch == CH_NEWLINE)
                        begin
                            r.echo_valid   = 1'b1;
                            r.echo_char    = ch;
                            r.request_done = 1'b1;
                            r.done_count   = chars_taken;
                            chars_left     = 12'd0;
                        end
                        else if (ch == CH_BACKSPACE && chars_taken != 12'd0)
                        begin
                            r.echo_valid = 1'b1;
                            r.echo_char  = ch;
                            chars_taken  = chars_taken - 12'd1;
                            chars_left   = chars_left + 12'd1;
                        end
                    end
                end
            end
            FUNC_ARM:
            begin
                chars_left  = b.size;
                chars_taken = 12'd0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_seen, name, got, want));
    endtask

    // Input driver: takes the next pending beat when the slot is free, unless it randomly idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            func         <= FUNC_PUSH;
            key_code     <= 8'h00;
            is_make      <= 1'b0;
            is_extended  <= 1'b0;
            request_size <= 12'h000;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                outcomes_due.push_back(discipline_outcome(
                    tty_beat_t'({func, key_code, is_make, is_extended, request_size})));
                beats_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt_beat = beats_to_send.pop_front();
                    in_valid     <= 1'b1;
                    func         <= nxt_beat.func;
                    key_code     <= nxt_beat.key;
                    is_make      <= nxt_beat.make;
                    is_extended  <= nxt_beat.ext;
                    request_size <= nxt_beat.size;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcomes_due.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                else
                begin : compare
                    tty_outcome_t want;
                    want = outcomes_due.pop_front();
                    check_field("store_valid", store_valid, want.store_valid);
                    check_field("store_index", store_index, want.store_index);
                    check_field("store_char", store_char, want.store_char);
                    check_field("echo_valid", echo_valid, want.echo_valid);
                    check_field("echo_char", echo_char, want.echo_char);
                    check_field("request_done", request_done, want.request_done);
                    check_field("done_count", done_count, want.done_count);
                    check_field("scroll_cmd", scroll_cmd, want.scroll_cmd);
                    check_field("dropped", dropped, want.dropped);
                    n_stores  += want.store_valid;
                    n_echoes  += want.echo_valid;
                    n_done    += want.request_done;
                    n_scrolls += (want.scroll_cmd != SCROLL_NONE);
                    n_drops   += want.dropped;
                end
                results_seen++;
            end
            // a requested hold-off overrides the random stalls
            if (stall_req)
            begin
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without any beat moving ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles, %0d results still due",
                         quiet_cycles, outcomes_due.size());
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_beat(input logic [1:0] f, input logic [7:0] k, input logic mk,
                              input logic ex, input logic [11:0] sz);
        beats_to_send.push_back(tty_beat_t'({f, k, mk, ex, sz}));
        beats_queued++;
    endtask

    task automatic queue_key(input logic [7:0] k);
        queue_beat(FUNC_PUSH, k, 1'b1, 1'b0, 12'($urandom));
        useful_beats++;
    endtask

    task automatic queue_drain();
        queue_beat(FUNC_DRAIN, 8'($urandom), 1'($urandom), 1'($urandom), 12'($urandom));
        useful_beats++;
    endtask

    task automatic queue_arm(input logic [11:0] sz);
        queue_beat(FUNC_ARM, 8'($urandom), 1'($urandom), 1'($urandom), sz);
        useful_beats++;
    endtask

    // Register write; only issued while nothing is in flight
    task automatic write_key_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_UP_KEY)
            up_code = val;
        else if (idx == CFG_DOWN_KEY)
            down_code = val;
        reg_writes++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (beats_sent != beats_queued || outcomes_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic hold_off_receiver();
        @(posedge clk);
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
    endtask

    // One typed line: arm, keys with noise and drains mixed in, then enough drains
    task automatic queue_line_session();
        int unsigned len;
        int unsigned pick;
        int unsigned owed;
        logic [7:0]  ch;
        pick = $urandom_range(99);
        if (pick < 5)
            queue_arm(12'd0);
        else if (pick < 12)
            queue_arm(12'($urandom));
        else
            queue_arm(12'($urandom_range(1, 16)));
        len  = $urandom_range(0, 14);
        owed = 0;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                ch = 8'($urandom_range(32, 126));
            else if (pick < 77)
                ch = CH_BACKSPACE;
            else if (pick < 83)
                ch = CH_NEWLINE;
            else
                ch = 8'($urandom);
            queue_key(ch);
            owed++;
            // noise: releases, extended keys, the unused code
            pick = $urandom_range(99);
            if (pick < 8)
                queue_beat(FUNC_PUSH, 8'($urandom), 1'b0, 1'($urandom), 12'($urandom));
            else if (pick < 16)
            begin
                case ($urandom_range(2))
                    0: ch = up_code;
                    1: ch = down_code;
                    default: ch = 8'($urandom);
                endcase
                queue_beat(FUNC_PUSH, ch, 1'b1, 1'b1, 12'($urandom));
            end
            else if (pick < 18)
                queue_beat(FUNC_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom),
                           12'($urandom));
            if (owed != 0 && $urandom_range(99) < 35)
            begin
                queue_drain();
                owed--;
            end
        end
        if ($urandom_range(99) < 60)
        begin
            queue_key(CH_NEWLINE);
            owed++;
        end
        repeat (owed + $urandom_range(0, 2)) queue_drain();
    endtask

    task automatic queue_random_phase();
        int unsigned goal;
        goal = useful_beats + RANDOM_PER_PH;
        while (useful_beats < goal)
            queue_line_session();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalling
        send_idle_pct = 9;
        recv_idle_pct = 83;

        // Directed part with both key codes at zero
        write_key_reg(CFG_UP_KEY, 8'h00);
        write_key_reg(CFG_DOWN_KEY, 8'h00);
        queue_drain();                                        // empty queue
        queue_beat(FUNC_PUSH, 8'h00, 1'b1, 1'b1, 12'hFFF);    // both codes match, up wins
        queue_beat(FUNC_PUSH, 8'hFF, 1'b1, 1'b1, 12'h000);    // extended, no match
        queue_beat(FUNC_PUSH, 8'hFF, 1'b0, 1'b1, 12'h000);    // release
        queue_beat(FUNC_UNUSED, 8'hFF, 1'b1, 1'b0, 12'hFFF);
        queue_key(8'h41);
        queue_drain();                                        // no read pending
        queue_arm(12'hFFF);
        queue_arm(12'h000);                                   // abandons, nothing pending
        queue_arm(12'd2);
        queue_key(CH_BACKSPACE);                              // backspace at count zero
        queue_key(CH_SPACE);
        queue_key(8'h1F);
        queue_key(CH_BACKSPACE);
        queue_key(CH_TILDE);
        queue_key(8'hFF);
        queue_key(8'h71);                                     // fills the request
        repeat (7) queue_drain();
        queue_arm(12'd5);
        queue_key(CH_NEWLINE);                                // completes with nothing read
        queue_drain();
        wait_idle();

        // Random lines with a long receiver hold-off at the start
        write_key_reg(CFG_UP_KEY, 8'hFF);
        write_key_reg(CFG_DOWN_KEY, 8'h00);
        queue_random_phase();
        hold_off_receiver();
        wait_idle();

        // Sender mostly idle, receiver mostly ready
        send_idle_pct = 83;
        recv_idle_pct = 9;
        write_key_reg(CFG_UP_KEY, 8'h48);
        write_key_reg(CFG_DOWN_KEY, 8'h50);
        queue_random_phase();
        wait_idle();

        // Neither side idles; equal codes so up has to win; then overfill the key queue
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_key_reg(CFG_UP_KEY, 8'h7E);
        write_key_reg(CFG_DOWN_KEY, 8'h7E);
        queue_random_phase();
        queue_arm(12'hFFF);
        repeat (258) queue_key(8'($urandom_range(32, 126)));
        repeat (12) queue_drain();
        hold_off_receiver();
        wait_idle();

        repeat (10) @(posedge clk);
        if (outcomes_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));

        $display("Covered %0d input beats and %0d checked results over %0d register writes:",
                 beats_sent, results_seen, reg_writes);
        $display("  %0d stores, %0d echoes, %0d reads completed, %0d scrolls, %0d drops",
                 n_stores, n_echoes, n_done, n_scrolls, n_drops);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
